[design/sha256s_pkg.sv]
`default_nettype none

package sha256s_pkg;

    // Working variables a through h of the compression rounds.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } work_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    // Initial hash value for digest word idx.
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    // Round constant for round j.
    function automatic logic [31:0] round_k(input logic [5:0] j);
        logic [31:0] v;
        case (j)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h428a2f98;
        endcase
        return v;
    endfunction

    // Upper-case sigma functions of the round.
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Lower-case sigma functions of the message schedule.
    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

[design/sha256s_if.sv]
`default_nettype none

// Message byte channel.
interface sha256s_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       final_item;

    modport source (output valid, data_byte, byte_valid, final_item, input ready);
    modport sink   (input valid, data_byte, byte_valid, final_item, output ready);
endinterface

// Digest word channel.
interface sha256s_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

[design/sha256_stream_hasher.sv]
`default_nettype none

// Channel   Role    Payload                                   Transfer
// msg       sink    data_byte[8], byte_valid, final_item      valid && ready
// digest    source  digest_word[32], word_index[3], last_word valid && ready
//
// A message byte is taken while msg.ready is high; every 64th byte starts a compression
// (load, 64 rounds through the single round unit, add into the hash state), and no byte
// is taken until it ends. A final item adds padding, the two length words and one or two
// compressions, then eight digest transfers; msg.ready is low throughout.
// Reset (rst_n, asynchronous) loads the initial hash value and clears all counters.
// The digest waits in its register for as long as digest.ready stays low.
module sha256_stream_hasher (
    input  wire logic               clk,
    input  wire logic               rst_n,
    sha256s_msg_if.sink             msg,
    sha256s_digest_if.source        digest
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUNDS,
        ST_ADD,
        ST_PAD,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [5:0]          byte_cnt_reg, byte_cnt_next;
    logic [60:0]         len_reg, len_next;
    logic [23:0]         acc_reg, acc_next;
    logic [31:0]         sched_reg [16];
    logic [31:0]         sched_next [16];
    logic [31:0]         hash_reg [8];
    logic [31:0]         hash_next [8];
    sha256s_pkg::work_t  work_reg, work_next;
    logic [5:0]          round_cnt_reg, round_cnt_next;
    logic [2:0]          out_cnt_reg, out_cnt_next;
    logic                fin_pend_reg, fin_pend_next;
    logic                pad_started_reg, pad_started_next;
    logic                len_done_reg, len_done_next;

    logic                pack_en;
    logic [7:0]          pack_byte;
    logic                sched_shift;
    logic [31:0]         sched_in;
    logic [23:0]         pack_acc;
    logic [31:0]         pack_word;
    logic                pack_word_done;
    logic [31:0]         expand_word;
    sha256s_pkg::work_t  round_out;
    sha256s_pkg::work_t  hash_work;

    // Shared datapath units.
    sha256s_pack u_pack (
        .acc       (acc_reg),
        .in_byte   (pack_byte),
        .lane      (byte_cnt_reg[1:0]),
        .acc_out   (pack_acc),
        .word      (pack_word),
        .word_done (pack_word_done)
    );

    sha256s_expand u_expand (
        .w0  (sched_reg[0]),
        .w1  (sched_reg[1]),
        .w9  (sched_reg[9]),
        .w14 (sched_reg[14]),
        .w16 (expand_word)
    );

    sha256s_round u_round (
        .cur (work_reg),
        .w   (sched_reg[0]),
        .k   (sha256s_pkg::round_k(round_cnt_reg)),
        .nxt (round_out)
    );

    assign hash_work = {hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                        hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};

    // Handshake and digest outputs.
    assign msg.ready          = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = hash_reg[0];
    assign digest.word_index  = out_cnt_reg;
    assign digest.last_word   = (out_cnt_reg == sha256s_pkg::WORD_LAST);

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        byte_cnt_next    = byte_cnt_reg;
        len_next         = len_reg;
        acc_next         = acc_reg;
        sched_next       = sched_reg;
        hash_next        = hash_reg;
        work_next        = work_reg;
        round_cnt_next   = round_cnt_reg;
        out_cnt_next     = out_cnt_reg;
        fin_pend_next    = fin_pend_reg;
        pad_started_next = pad_started_reg;
        len_done_next    = len_done_reg;
        pack_en          = 1'b0;
        pack_byte        = 8'h00;
        sched_shift      = 1'b0;
        sched_in         = expand_word;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    fin_pend_next = msg.final_item;
                    if (msg.byte_valid)
                    begin
                        pack_en   = 1'b1;
                        pack_byte = msg.data_byte;
                        len_next  = len_reg + 61'd1;
                        if (byte_cnt_reg == sha256s_pkg::BLOCK_LAST)
                        begin
                            state_next = ST_LOAD;
                        end
                        else if (msg.final_item)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (msg.final_item)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                work_next      = hash_work;
                round_cnt_next = '0;
                state_next     = ST_ROUNDS;
            end
            ST_ROUNDS:
            begin
                work_next      = round_out;
                sched_shift    = 1'b1;
                sched_in       = expand_word;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == sha256s_pkg::ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                hash_next[0] = hash_reg[0] + work_reg.a;
                hash_next[1] = hash_reg[1] + work_reg.b;
                hash_next[2] = hash_reg[2] + work_reg.c;
                hash_next[3] = hash_reg[3] + work_reg.d;
                hash_next[4] = hash_reg[4] + work_reg.e;
                hash_next[5] = hash_reg[5] + work_reg.f;
                hash_next[6] = hash_reg[6] + work_reg.g;
                hash_next[7] = hash_reg[7] + work_reg.h;
                if (len_done_reg)
                begin
                    out_cnt_next = '0;
                    state_next   = ST_OUT;
                end
                else if (fin_pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (pad_started_reg && (byte_cnt_reg == sha256s_pkg::LEN_POS))
                begin
                    state_next = ST_LEN_HI;
                end
                else
                begin
                    pack_en          = 1'b1;
                    pack_byte        = pad_started_reg ? 8'h00 : sha256s_pkg::PAD_BYTE;
                    pad_started_next = 1'b1;
                    if (byte_cnt_reg == sha256s_pkg::BLOCK_LAST)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LEN_HI:
            begin
                sched_shift = 1'b1;
                sched_in    = len_reg[60:29];
                state_next  = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                sched_shift   = 1'b1;
                sched_in      = {len_reg[28:0], 3'b000};
                len_done_next = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_OUT:
            begin
                if (digest.ready)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        hash_next[i] = hash_reg[i + 1];
                    end
                    hash_next[7] = sha256s_pkg::init_hash(out_cnt_reg);
                    out_cnt_next = out_cnt_reg + 3'd1;
                    if (out_cnt_reg == sha256s_pkg::WORD_LAST)
                    begin
                        byte_cnt_next    = '0;
                        len_next         = '0;
                        fin_pend_next    = 1'b0;
                        pad_started_next = 1'b0;
                        len_done_next    = 1'b0;
                        state_next       = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Byte packing; each completed word moves into the schedule line.
        if (pack_en)
        begin
            acc_next      = pack_acc;
            byte_cnt_next = byte_cnt_reg + 6'd1;
            if (pack_word_done)
            begin
                sched_shift = 1'b1;
                sched_in    = pack_word;
            end
        end

        if (sched_shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[15] = sched_in;
        end
    end

    // State and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            byte_cnt_reg    <= '0;
            len_reg         <= '0;
            round_cnt_reg   <= '0;
            out_cnt_reg     <= '0;
            fin_pend_reg    <= 1'b0;
            pad_started_reg <= 1'b0;
            len_done_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha256s_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg       <= state_next;
            byte_cnt_reg    <= byte_cnt_next;
            len_reg         <= len_next;
            round_cnt_reg   <= round_cnt_next;
            out_cnt_reg     <= out_cnt_next;
            fin_pend_reg    <= fin_pend_next;
            pad_started_reg <= pad_started_next;
            len_done_reg    <= len_done_next;
            hash_reg        <= hash_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        sched_reg <= sched_next;
        work_reg  <= work_next;
    end

    // The block never takes a byte while a digest word is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(msg.ready && digest.valid))
        else $error("message accepted while digest pending");

    // The length words go in only after padding has reached byte 56.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN_HI) |-> (pad_started_reg && byte_cnt_reg == sha256s_pkg::LEN_POS))
        else $error("length words out of place");

    // Each compression starts at round zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_ROUNDS && round_cnt_reg == 6'd0))
        else $error("rounds did not start at zero");

    // Digest words leave in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && !digest.last_word)
        |=> (digest.valid && digest.word_index == $past(digest.word_index) + 3'd1))
        else $error("digest word order broken");

    // After the last digest word the block is ready for a new message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.last_word)
        |=> (msg.ready && byte_cnt_reg == 6'd0 && len_reg == 61'd0))
        else $error("block not cleared after digest");

endmodule

`default_nettype wire

[design/sha256s_round.sv]
`default_nettype none

// One SHA-256 compression round, reused for all 64 rounds of a block.
module sha256s_round (
    input  var sha256s_pkg::work_t cur,
    input  wire logic [31:0]       w,
    input  wire logic [31:0]       k,
    output var sha256s_pkg::work_t nxt
);

    logic [31:0] ch;
    logic [31:0] mj;
    logic [31:0] t1;
    logic [31:0] t2;

    // Choose and majority, then the two temporaries.
    assign ch = (cur.e & cur.f) ^ (~cur.e & cur.g);
    assign mj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    assign t1 = cur.h + sha256s_pkg::big_sigma1(cur.e) + ch + k + w;
    assign t2 = sha256s_pkg::big_sigma0(cur.a) + mj;

    // Rotate the working variables.
    always_comb
    begin
        nxt.a = t1 + t2;
        nxt.b = cur.a;
        nxt.c = cur.b;
        nxt.d = cur.c;
        nxt.e = cur.d + t1;
        nxt.f = cur.e;
        nxt.g = cur.f;
        nxt.h = cur.g;
    end

endmodule

`default_nettype wire

[design/sha256s_expand.sv]
`default_nettype none

// Message schedule expansion: W[j+16] from the taps W[j], W[j+1], W[j+9], W[j+14].
module sha256s_expand (
    input  wire logic [31:0] w0,
    input  wire logic [31:0] w1,
    input  wire logic [31:0] w9,
    input  wire logic [31:0] w14,
    output wire logic [31:0] w16
);

    assign w16 = w0 + sha256s_pkg::small_sigma0(w1) + w9 + sha256s_pkg::small_sigma1(w14);

endmodule

`default_nettype wire

[design/sha256s_stream_top_placeholder.sv]
`default_nettype none

// Byte packer: gathers message bytes big-endian into 32-bit schedule words.
module sha256s_pack (
    input  wire logic [23:0] acc,
    input  wire logic [7:0]  in_byte,
    input  wire logic [1:0]  lane,
    output wire logic [23:0] acc_out,
    output wire logic [31:0] word,
    output wire logic        word_done
);

    assign acc_out   = {acc[15:0], in_byte};
    assign word      = {acc, in_byte};
    assign word_done = (lane == 2'b11);

endmodule

`default_nettype wire

[tb/sha256s_digest_check.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps its own SHA-256 state, and compares every digest
// transfer against the oldest predicted digest word.
module sha256s_digest_check (
    input  logic        clk,
    input  logic        rst_n,
    sha256s_msg_if      msg,
    sha256s_digest_if   digest,
    output int          errors,
    output int          pending,
    output int          checked
);

    // Initial hash value, word 0 in the top 32 bits.
    localparam logic [255:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants, round 0 in the top 32 bits.
    localparam logic [2047:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  slot;
        logic        last;
    } digest_beat_t;

    // Predicted digest words, oldest first.
    digest_beat_t expected_words[$];
    digest_beat_t want;

    // Running hash of the message in progress.
    logic [31:0] chain [8];
    logic [31:0] wblk [16];
    logic [5:0]  fill;
    logic [63:0] bit_len;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Drop byte b into block position pos, big-endian within its word.
    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
        logic [31:0] lane;
        lane = {24'd0, b} << (5'd24 - {pos[1:0], 3'b000});
        if (pos[1:0] == 2'd0)
            wblk[pos[5:2]] = lane;
        else
            wblk[pos[5:2]] |= lane;
    endfunction

    // Sixty-four rounds over the block with a rolling schedule.
    function automatic void compress_block();
        logic [31:0] v [8];
        logic [31:0] w, w15, w2, s0, s1, ch, mj, t1;
        int j;
        for (j = 0; j < 8; j++)
            v[j] = chain[j];
        for (j = 0; j < 64; j++)
        begin
            if (j < 16)
                w = wblk[j];
            else
            begin
                w15 = wblk[(j - 15) & 15];
                w2  = wblk[(j - 2) & 15];
                w = wblk[j & 15] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                    + wblk[(j - 7) & 15] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
                wblk[j & 15] = w;
            end
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + ROUND_K[(63 - j) * 32 +: 32] + w;
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + s0 + mj;
        end
        for (j = 0; j < 8; j++)
            chain[j] = chain[j] + v[j];
    endfunction

    function automatic void start_message();
        int j;
        for (j = 0; j < 8; j++)
            chain[j] = IV[(7 - j) * 32 +: 32];
        fill = 6'd0;
        bit_len = 64'd0;
    endfunction

    // Absorb one message transfer; a final item pads and queues the digest.
    function automatic void absorb_item(input logic [7:0] b, input logic bv, input logic fin);
        digest_beat_t beat;
        int pos;
        int j;
        if (bv)
        begin
            place_byte(fill, b);
            bit_len = bit_len + 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress_block();
        end
        if (fin)
        begin
            pos = int'(fill);
            place_byte(6'(pos), sha256s_pkg::PAD_BYTE);
            pos++;
            // Not enough room for the length: pad out and spill into a second block.
            if (pos > int'(sha256s_pkg::LEN_POS))
            begin
                while (pos < 64)
                begin
                    place_byte(6'(pos), 8'h00);
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < int'(sha256s_pkg::LEN_POS))
            begin
                place_byte(6'(pos), 8'h00);
                pos++;
            end
            wblk[14] = bit_len[63:32];
            wblk[15] = bit_len[31:0];
            compress_block();
            for (j = 0; j < 8; j++)
            begin
                beat.word = chain[j];
                beat.slot = j[2:0];
                beat.last = (j[2:0] == sha256s_pkg::WORD_LAST);
                expected_words.push_back(beat);
            end
            start_message();
        end
    endfunction

    // Predict on message transfers, compare on digest transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_message();
            expected_words.delete();
            errors = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            if (msg.valid && msg.ready)
                absorb_item(msg.data_byte, msg.byte_valid, msg.final_item);
            if (digest.valid && digest.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected digest transfer: word %h index %0d",
                           digest.digest_word, digest.word_index);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked++;
                    if (digest.digest_word !== want.word)
                    begin
                        $error("digest_word: expected %h, got %h", want.word,
                               digest.digest_word);
                        errors++;
                    end
                    if (digest.word_index !== want.slot)
                    begin
                        $error("word_index: expected %0d, got %0d", want.slot,
                               digest.word_index);
                        errors++;
                    end
                    if (digest.last_word !== want.last)
                    begin
                        $error("last_word: expected %0d, got %0d", want.last,
                               digest.last_word);
                        errors++;
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 80;

    // Message lengths that sit on block and padding boundaries.
    localparam int EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int err_count;
    int words_pending;
    int words_checked;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_req = 1'b0;

    int item_count = 0;
    int noise_count = 0;
    int msg_count = 0;
    int longest = 0;
    int quiet_cycles = 0;

    sha256s_msg_if    msg ();
    sha256s_digest_if digest ();

    sha256_stream_hasher u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    sha256s_digest_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg),
        .digest  (digest),
        .errors  (err_count),
        .pending (words_pending),
        .checked (words_checked)
    );

    always #10 clk = ~clk;

    // Offer one item, with random idle cycles ahead of it, and wait for its transfer.
    task automatic send_item(input logic [7:0] d, input logic bv, input logic fin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg.valid <= 1'b0;
            @(negedge clk);
        end
        msg.valid      <= 1'b1;
        msg.data_byte  <= d;
        msg.byte_valid <= bv;
        msg.final_item <= fin;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
        @(negedge clk);
        if (bv || fin)
            item_count++;
        else
            noise_count++;
        if (fin)
            msg_count++;
    endtask

    // One message of random bytes; the final flag rides on the last byte or
    // comes alone, and empty items are scattered in between.
    task automatic send_message(input int len);
        bit joint;
        int k;
        joint = (len > 0) && ($urandom_range(1) == 1);
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < 8)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, joint && (k == len - 1));
        end
        if (!joint)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        if (len > longest)
            longest = len;
    endtask

    // Mostly short messages, a good share on block boundaries, some anywhere.
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(12);
        else if (r < 75)
            return EDGE_LENGTHS[$urandom_range(9)];
        else
            return $urandom_range(140);
    endfunction

    // Digest receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        digest.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                digest.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            digest.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: ends the run when nothing transfers for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (msg.valid && msg.ready) || (digest.valid && digest.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d digest words outstanding",
                     WATCHDOG_LIMIT, words_pending);
            $display("testbench: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict.
    initial
    begin
        int phase;
        int phase_start;
        msg.valid      = 1'b0;
        msg.data_byte  = 8'h00;
        msg.byte_valid = 1'b0;
        msg.final_item = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty message, lone bytes at both extremes, byte and final
        // together, final after bytes, and ignored items around them.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hfe, 1'b1, 1'b1);

        // Random messages under four handshake mixes.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    // Long receiver hold-off so the block backs up into the message side.
                    hold_req = 1'b1;
                end
                1:
                begin
                    src_idle_pct = 74;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 74;
                end
                default:
                begin
                    src_idle_pct = 6;
                    sink_stall_pct = 6;
                end
            endcase
            phase_start = item_count;
            while (item_count - phase_start < PHASE_ITEMS)
                send_message(pick_length());
        end
        msg.valid <= 1'b0;

        // Drain the outstanding digests, then watch for stray transfers.
        wait (words_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d message items (%0d empty items) in %0d messages, up to %0d bytes,",
                 item_count, noise_count, msg_count, longest);
        $display("under four idle/stall mixes and one long hold-off; %0d digest words compared.",
                 words_checked);
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[filelist.f]
design/sha256s_pkg.sv
design/sha256s_if.sv
design/sha256s_round.sv
design/sha256s_expand.sv
design/sha256s_stream_top_placeholder.sv
design/sha256_stream_hasher.sv
tb/sha256s_digest_check.sv
tb/testbench.sv
